// ===== src/assert_macros.svh =====
// Assertion helpers used by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked assertion, disabled while reset is low
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("%m: check failed");
// Clocked implication, disabled while reset is low
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: check failed");
`endif

// ===== src/lfu_pkg.sv =====
package lfu_pkg;

  localparam int unsigned MaxEntriesDef = 16;
  localparam int unsigned CountBitsDef  = 16;
  localparam int unsigned CapW          = 5;
  localparam logic [CapW-1:0] CapReset  = 5'd16;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StScanEnd,
    StDecide,
    StPass,
    StPassEnd,
    StWrite,
    StFin
  } state_e;

endpackage

// ===== src/lfu_ram.sv =====
module lfu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/lfu_cache_with_lru_ties_top.sv =====
// Each accepted word runs a key/victim scan of the entry RAM; a hit or a set that evicts then
//   does a rank pass and a write; a get miss skips both, and a set into a free slot only writes.
// Throughput: one request at a time; set by the entry RAM sweeps (key/victim scan, rank pass).
// A new request is taken while the previous result still waits in the output register.
// Reset (async, active low) clears valid bits, occupancy and handshakes; capacity returns to 16.
`include "assert_macros.svh"

module lfu_cache_with_lru_ties_top #(
  parameter int unsigned MAX_ENTRIES = lfu_pkg::MaxEntriesDef,
  parameter int unsigned COUNT_BITS  = lfu_pkg::CountBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [lfu_pkg::CapW-1:0]  cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      req_type_i,
  input  logic signed [31:0]        key_i,
  input  logic signed [31:0]        value_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      hit_o,
  output logic signed [31:0]        read_value_o
);
  import lfu_pkg::*;

  localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned OW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned EW = 64 + COUNT_BITS + IW;
  localparam logic [IW-1:0] LastIdx = IW'(MAX_ENTRIES - 1);
  localparam logic [OW-1:0] MaxOcc  = OW'(MAX_ENTRIES);

  state_e state_q, state_d;

  logic [CapW-1:0]        cap_q;
  logic [MAX_ENTRIES-1:0] valid_q;
  logic [OW-1:0]          occ_q;
  logic [OW-1:0]          eff_cap;

  // request word
  logic        req_set_q;
  logic [31:0] req_key_q, req_val_q;

  // sweep control
  logic [IW-1:0] idx_q;
  logic          rd_vld_q;
  logic [IW-1:0] rd_idx_q;

  // scan results
  logic                  found_q, vic_q, free_q;
  logic [IW-1:0]         fidx_q, vidx_q, free_idx_q;
  logic [31:0]           fval_q;
  logic [COUNT_BITS-1:0] fcnt_q, vcnt_q;
  logic [IW-1:0]         frank_q, vrank_q;

  // action decided
  logic          evict_q;
  logic [IW-1:0] skip_q, drop_q, slot_q;
  logic          res_hit_q;
  logic [31:0]   res_val_q;

  logic          out_valid_q, out_hit_q;
  logic [31:0]   out_val_q;

  // RAM port
  logic          ram_we;
  logic [IW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;

  logic [31:0]           rd_key;
  logic [COUNT_BITS-1:0] rd_cnt;
  logic [IW-1:0]         rd_rank;
  logic                  rd_live, scanning, passing, out_load, need_evict;

  assign rd_key  = ram_rdata[EW-1 -: 32];
  assign rd_cnt  = ram_rdata[IW +: COUNT_BITS];
  assign rd_rank = ram_rdata[IW-1:0];
  assign rd_live = rd_vld_q && valid_q[rd_idx_q];

  // effective capacity, clamped to 1..MAX_ENTRIES
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = OW'(1);
    end else if (32'(cap_q) > MAX_ENTRIES) begin
      eff_cap = MaxOcc;
    end else begin
      eff_cap = OW'(cap_q);
    end
  end

  assign need_evict = (occ_q >= eff_cap);
  assign out_load   = (state_q == StFin) && (!out_valid_q || out_ready_i);

  lfu_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_ENTRIES),
    .AW    (IW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:    if (in_valid_i) state_d = StScan;
      StScan:    if (idx_q == LastIdx) state_d = StScanEnd;
      StScanEnd: state_d = StDecide;
      StDecide: begin
        if (found_q) begin
          state_d = StPass;
        end else if (!req_set_q) begin
          state_d = StFin;
        end else if (need_evict) begin
          state_d = StPass;
        end else begin
          state_d = StWrite;
        end
      end
      StPass:    if (idx_q == LastIdx) state_d = StPassEnd;
      StPassEnd: state_d = StWrite;
      StWrite:   state_d = StFin;
      StFin:     if (out_load) state_d = StIdle;
      default:   state_d = StIdle;
    endcase
  end

  // outputs of the sequencer: handshake and RAM port
  always_comb begin
    in_ready_o = (state_q == StIdle);
    scanning   = (state_q == StScan) || (state_q == StScanEnd);
    passing    = (state_q == StPass) || (state_q == StPassEnd);
    ram_raddr  = idx_q;
    ram_we     = 1'b0;
    ram_waddr  = rd_idx_q;
    ram_wdata  = {ram_rdata[EW-1:IW], rd_rank - IW'(1)};
    if (passing && rd_live && (rd_idx_q != skip_q) && (rd_rank > drop_q)) begin
      ram_we = 1'b1;
    end
    if (state_q == StWrite) begin
      ram_we    = 1'b1;
      ram_waddr = slot_q;
      if (found_q) begin
        ram_wdata = {req_key_q, (req_set_q ? req_val_q : fval_q),
                     ((&fcnt_q) ? fcnt_q : fcnt_q + COUNT_BITS'(1)),
                     IW'(occ_q - OW'(1))};
      end else begin
        ram_wdata = {req_key_q, req_val_q, {COUNT_BITS{1'b0}},
                     IW'(evict_q ? occ_q - OW'(1) : occ_q)};
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cap_q       <= CapReset;
      valid_q     <= '0;
      occ_q       <= '0;
      idx_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      rd_vld_q <= (state_q == StScan) || (state_q == StPass);
      if ((state_q == StScan) || (state_q == StPass)) begin
        idx_q <= (idx_q == LastIdx) ? '0 : idx_q + IW'(1);
      end
      if ((state_q == StWrite) && !found_q) begin
        if (evict_q) begin
          valid_q <= (valid_q & ~(MAX_ENTRIES'(1) << vidx_q)) | (MAX_ENTRIES'(1) << slot_q);
        end else begin
          valid_q <= valid_q | (MAX_ENTRIES'(1) << slot_q);
          occ_q   <= occ_q + OW'(1);
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    rd_idx_q <= idx_q;
    if (in_valid_i && in_ready_o) begin
      req_set_q <= req_type_i;
      req_key_q <= key_i;
      req_val_q <= value_i;
      found_q   <= 1'b0;
      vic_q     <= 1'b0;
      free_q    <= 1'b0;
    end
    // key match, victim and first free slot
    if (scanning && rd_vld_q) begin
      if (rd_live) begin
        if ((rd_key == req_key_q) && !found_q) begin
          found_q <= 1'b1;
          fidx_q  <= rd_idx_q;
          fval_q  <= ram_rdata[IW+COUNT_BITS +: 32];
          fcnt_q  <= rd_cnt;
          frank_q <= rd_rank;
        end
        if (!vic_q || (rd_cnt < vcnt_q) || ((rd_cnt == vcnt_q) && (rd_rank < vrank_q))) begin
          vic_q   <= 1'b1;
          vidx_q  <= rd_idx_q;
          vcnt_q  <= rd_cnt;
          vrank_q <= rd_rank;
        end
      end else if (!free_q) begin
        free_q     <= 1'b1;
        free_idx_q <= rd_idx_q;
      end
    end
    if (state_q == StDecide) begin
      res_hit_q <= found_q;
      res_val_q <= found_q ? (req_set_q ? 32'd0 : fval_q) : (req_set_q ? 32'd0 : 32'hFFFF_FFFF);
      evict_q   <= !found_q && need_evict;
      if (found_q) begin
        skip_q <= fidx_q;
        drop_q <= frank_q;
        slot_q <= fidx_q;
      end else begin
        skip_q <= vidx_q;
        drop_q <= vrank_q;
        if (need_evict) begin
          slot_q <= (free_q && (free_idx_q < vidx_q)) ? free_idx_q : vidx_q;
        end else begin
          slot_q <= free_idx_q;
        end
      end
    end
    if (out_load) begin
      out_hit_q <= res_hit_q;
      out_val_q <= res_val_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hit_o        = out_hit_q;
  assign read_value_o = out_val_q;

  `ASSERT_CLK(a_occ_matches_valid, clk_i, rst_ni, 32'(occ_q) == 32'($countones(valid_q)))
  `ASSERT_IMP(a_accept_starts_scan, clk_i, rst_ni, in_valid_i && in_ready_o, state_q == StScan)
  `ASSERT_IMP(a_fin_holds_on_stall, clk_i, rst_ni, (state_q == StFin) && out_valid_q && !out_ready_i, state_q == StFin)

endmodule
